// ----- design/mcr_pkg.sv -----
`default_nettype none

package mcr_pkg;

    // drawing limits
    localparam int MAX_RADIUS  = 64;
    localparam int COORD_BITS  = 13;

    // field widths
    localparam int RADIUS_IN_BITS = 7;
    localparam int OFFSET_BITS    = 6;
    localparam int MASK_BITS      = 8;
    localparam int CFG_BITS       = 13;
    localparam int CFG_IDX_BITS   = 1;

    // internal recurrence widths
    localparam int RAD_BITS   = $clog2(MAX_RADIUS + 1);
    localparam int DIAM_BITS  = RAD_BITS + 1;
    localparam int STEP_BITS  = RAD_BITS + 2;
    localparam int ERR_BITS   = RAD_BITS + 4;
    localparam int PT_BITS    = COORD_BITS + RAD_BITS;

    // stream packing
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 48;
    localparam int OUT_USED_BITS = 2 * COORD_BITS + 2 * OFFSET_BITS + MASK_BITS;

    // command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SURFACE_HEIGHT = 1'b1;

    localparam logic [CFG_BITS-1:0] SURFACE_WIDTH_RESET  = 13'd640;
    localparam logic [CFG_BITS-1:0] SURFACE_HEIGHT_RESET = 13'd480;

    // circle command after classification
    typedef struct packed {
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [RAD_BITS-1:0]   radius;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [COORD_BITS-1:0]  center_x;
        logic [COORD_BITS-1:0]  center_y;
        logic [OFFSET_BITS-1:0] offset_major;
        logic [OFFSET_BITS-1:0] offset_minor;
        logic [MASK_BITS-1:0]   visible_mask;
        logic                   last;
    } result_t;

    // queue head handshake from the queue to the back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_out_t;

    // point inside surface test on a sign-extended coordinate pair
    function automatic logic inside_surface(
        logic [PT_BITS-1:0]  px,
        logic [PT_BITS-1:0]  py,
        logic [CFG_BITS-1:0] w,
        logic [CFG_BITS-1:0] h
    );
        logic in_x;
        logic in_y;
        in_x = !px[PT_BITS-1] && (px < PT_BITS'(w));
        in_y = !py[PT_BITS-1] && (py < PT_BITS'(h));
        return in_x && in_y;
    endfunction

    // visibility of the eight symmetric points
    function automatic logic [MASK_BITS-1:0] point_mask(
        logic [COORD_BITS-1:0] cx,
        logic [COORD_BITS-1:0] cy,
        logic [RAD_BITS-1:0]   a,
        logic [RAD_BITS-1:0]   b,
        logic [CFG_BITS-1:0]   w,
        logic [CFG_BITS-1:0]   h
    );
        logic [PT_BITS-1:0]   x_ext;
        logic [PT_BITS-1:0]   y_ext;
        logic [PT_BITS-1:0]   a_ext;
        logic [PT_BITS-1:0]   b_ext;
        logic [MASK_BITS-1:0] m;
        x_ext = {{(PT_BITS - COORD_BITS){cx[COORD_BITS-1]}}, cx};
        y_ext = {{(PT_BITS - COORD_BITS){cy[COORD_BITS-1]}}, cy};
        a_ext = PT_BITS'(a);
        b_ext = PT_BITS'(b);
        m[0] = inside_surface(x_ext + a_ext, y_ext - b_ext, w, h);
        m[1] = inside_surface(x_ext + a_ext, y_ext + b_ext, w, h);
        m[2] = inside_surface(x_ext - a_ext, y_ext - b_ext, w, h);
        m[3] = inside_surface(x_ext - a_ext, y_ext + b_ext, w, h);
        m[4] = inside_surface(x_ext + b_ext, y_ext - a_ext, w, h);
        m[5] = inside_surface(x_ext + b_ext, y_ext + a_ext, w, h);
        m[6] = inside_surface(x_ext - b_ext, y_ext - a_ext, w, h);
        m[7] = inside_surface(x_ext - b_ext, y_ext + a_ext, w, h);
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- design/midpoint_circle_rasterizer.sv -----
// channel | direction | tdata fields, lowest bit first                          | tlast
// s_axis  | in        | center_x 13, center_y 13, radius 7, zero fill to 40     | -
// m_axis  | out       | echo_center_x 13, echo_center_y 13, offset_major 6,     | last
//         |           | offset_minor 6, visible_mask 8, zero fill to 48         |
// cfg     | in        | cfg_index 0 surface_width, 1 surface_height; 13-bit data| -
//
// a circle of radius r gives about 0.71*r items, one item per cycle while the output
// is not stalled, after a setup step; the rate is set by the single-step iterator
// a two-entry command queue lets the input side take commands while a circle runs
// a stalled output holds the iterator; zero radius commands are taken and dropped
// reset empties the queue, stops the iterator and sets the surface to 640 by 480
`default_nettype none

module midpoint_circle_rasterizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x [12:0], center_y [25:13], radius [32:26]
    input  logic [mcr_pkg::IN_DATA_BITS-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // echo_center_x [12:0], echo_center_y [25:13], offset_major [31:26],
    // offset_minor [37:32], visible_mask [45:38]
    output logic [mcr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mcr_pkg::CFG_BITS-1:0]        cfg_data
);
    import mcr_pkg::*;

    logic [CFG_BITS-1:0] width_reg;
    logic [CFG_BITS-1:0] width_next;
    logic [CFG_BITS-1:0] height_reg;
    logic [CFG_BITS-1:0] height_next;

    logic       q_ready;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_pop;
    queue_out_t q_head;
    result_t    result;

    // configuration registers
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SURFACE_WIDTH:  width_next  = cfg_data;
                REG_SURFACE_HEIGHT: height_next = cfg_data;
                default:            width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SURFACE_WIDTH_RESET;
            height_reg <= SURFACE_HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // command intake
    mcr_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // command queue
    mcr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .head     (q_head)
    );

    // circle iterator and output register
    mcr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .surface_width  (width_reg),
        .surface_height (height_reg),
        .head           (q_head),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .result         (result)
    );

    // pack the result item
    assign m_tdata = {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
                      result.visible_mask,
                      result.offset_minor,
                      result.offset_major,
                      result.center_y,
                      result.center_x};
    assign m_tlast = result.last;

endmodule

`default_nettype wire

// ----- design/mcr_front.sv -----
`default_nettype none

module mcr_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // center_x [12:0], center_y [25:13], radius [32:26], zero fill above
    input  logic [mcr_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic                                q_ready,
    output logic                                q_push,
    output mcr_pkg::cmd_t                       q_cmd
);
    import mcr_pkg::*;

    logic [COORD_BITS-1:0]     cx;
    logic [COORD_BITS-1:0]     cy;
    logic [RADIUS_IN_BITS-1:0] radius_in;
    logic                      radius_zero;

    // unpack the command
    assign cx        = s_tdata[COORD_BITS-1:0];
    assign cy        = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign radius_in = s_tdata[2*COORD_BITS+RADIUS_IN_BITS-1:2*COORD_BITS];
    assign radius_zero = (radius_in == '0);

    // saturate radius to the maximum
    always_comb
    begin
        q_cmd.center_x = cx;
        q_cmd.center_y = cy;
        if (int'(radius_in) > MAX_RADIUS)
        begin
            q_cmd.radius = RAD_BITS'(MAX_RADIUS);
        end
        else
        begin
            q_cmd.radius = RAD_BITS'(radius_in);
        end
    end

    // zero radius items are taken and dropped
    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && !radius_zero;

endmodule

`default_nettype wire

// ----- design/mcr_queue.sv -----
`default_nettype none

module mcr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mcr_pkg::cmd_t       push_cmd,
    output logic                ready,
    input  logic                pop,
    output mcr_pkg::queue_out_t head
);
    import mcr_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;
    logic                 do_push;
    logic                 do_pop;

    assign ready    = (count_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign do_push  = push && ready;
    assign do_pop   = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- design/mcr_back.sv -----
`default_nettype none

module mcr_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [mcr_pkg::CFG_BITS-1:0]    surface_width,
    input  logic [mcr_pkg::CFG_BITS-1:0]    surface_height,
    input  mcr_pkg::queue_out_t             head,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output mcr_pkg::result_t                result
);
    import mcr_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic [RAD_BITS-1:0]   a_reg;
    logic [RAD_BITS-1:0]   a_next;
    logic [RAD_BITS-1:0]   b_reg;
    logic [RAD_BITS-1:0]   b_next;
    logic [STEP_BITS-1:0]  major_step_reg;
    logic [STEP_BITS-1:0]  major_step_next;
    logic [STEP_BITS-1:0]  minor_step_reg;
    logic [STEP_BITS-1:0]  minor_step_next;
    logic [ERR_BITS-1:0]   err_reg;
    logic [ERR_BITS-1:0]   err_next;
    logic [DIAM_BITS-1:0]  diam_reg;
    logic [DIAM_BITS-1:0]  diam_next;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cx_next;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-1:0] cy_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    result_t               out_reg;
    result_t               out_next;

    logic                  start;
    logic                  advance;
    logic [ERR_BITS-1:0]   err_b;
    logic [RAD_BITS-1:0]   b_step;
    logic [STEP_BITS-1:0]  minor_step_b;
    logic [ERR_BITS-1:0]   err_a;
    logic [RAD_BITS-1:0]   a_step;
    logic [STEP_BITS-1:0]  major_step_a;
    logic                  more;

    assign start   = !busy_reg && head.valid;
    assign advance = busy_reg && (!out_valid_reg || m_tready);
    assign q_pop   = start;

    // one recurrence iteration
    always_comb
    begin
        err_b        = err_reg;
        b_step       = b_reg;
        minor_step_b = minor_step_reg;
        if (err_reg[ERR_BITS-1] || (err_reg == '0))
        begin
            b_step       = b_reg + 1'b1;
            err_b        = err_reg + ERR_BITS'(minor_step_reg);
            minor_step_b = minor_step_reg + STEP_BITS'(2);
        end
        err_a        = err_b;
        a_step       = a_reg;
        major_step_a = major_step_reg;
        if (!err_b[ERR_BITS-1] && (err_b != '0))
        begin
            a_step       = a_reg - 1'b1;
            major_step_a = major_step_reg + STEP_BITS'(2);
            err_a        = err_b + ERR_BITS'(major_step_a) - ERR_BITS'(diam_reg);
        end
        more = (a_step >= b_step);
    end

    // circle setup and iteration state
    always_comb
    begin
        busy_next       = busy_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        major_step_next = major_step_reg;
        minor_step_next = minor_step_reg;
        err_next        = err_reg;
        diam_next       = diam_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        if (start)
        begin
            busy_next       = 1'b1;
            a_next          = head.cmd.radius - 1'b1;
            b_next          = '0;
            major_step_next = STEP_BITS'(1);
            minor_step_next = STEP_BITS'(1);
            diam_next       = {head.cmd.radius, 1'b0};
            err_next        = ERR_BITS'(1) - ERR_BITS'({head.cmd.radius, 1'b0});
            cx_next         = head.cmd.center_x;
            cy_next         = head.cmd.center_y;
        end
        else if (advance)
        begin
            busy_next       = more;
            a_next          = a_step;
            b_next          = b_step;
            major_step_next = major_step_a;
            minor_step_next = minor_step_b;
            err_next        = err_a;
        end
    end

    // output register
    always_comb
    begin
        out_next              = out_reg;
        out_valid_next        = out_valid_reg && !m_tready;
        if (advance)
        begin
            out_valid_next        = 1'b1;
            out_next.center_x     = cx_reg;
            out_next.center_y     = cy_reg;
            out_next.offset_major = a_reg[OFFSET_BITS-1:0];
            out_next.offset_minor = b_reg[OFFSET_BITS-1:0];
            out_next.visible_mask = point_mask(cx_reg, cy_reg, a_reg, b_reg,
                                               surface_width, surface_height);
            out_next.last         = !more;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        major_step_reg <= major_step_next;
        minor_step_reg <= minor_step_next;
        err_reg        <= err_next;
        diam_reg       <= diam_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        out_reg        <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign result   = out_reg;

`ifndef SYNTHESIS
    // the octant walk never runs past the diagonal
    a_octant: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (a_reg >= b_reg))
        else $error("major offset below minor offset while drawing");

    // a last item ends the circle
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && out_next.last) |=> !busy_reg)
        else $error("circle still running after last item");

    // an empty output slot is always filled while drawing
    a_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("iteration stalled with a free output slot");

    // a running circle always has a nonzero diameter
    a_diam: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (diam_reg != '0))
        else $error("zero radius circle reached the iterator");
`endif

endmodule

`default_nettype wire
